// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the top-level rtl file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the rising clock edge, off during reset
`define APD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication check, consequent in the same cycle
`define APD_ASSERT_IMP(lbl, ante, cons, msg) \
   `APD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- sv/appd_pkg.sv -----
// ---------------------------------------------------------------------------
// appd_pkg
// shared constants and types for the box pair distance pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package appd_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int PAD_BITS       = 31;
   localparam int DIR_BITS       = 16;
   localparam int QUOT_BITS      = 16;
   localparam int FRAC_SHIFT     = 15;
   localparam logic [DIR_BITS-1:0] DIR_POS_MAX = 16'h7FFF;

   typedef struct packed {
      logic ok;
      logic ov;
   } flag_type;

   localparam int FLAG_BITS = $bits(flag_type);

endpackage

// ----- sv/appd_front.sv -----
// ---------------------------------------------------------------------------
// appd_front
// ordering and overlap checks, closest points, gap squares and their sum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module appd_front #(
   parameter int COORD_BITS = appd_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [appd_pkg::PAD_BITS-1:0] pad,
   input  logic in_valid,
   output logic in_stall,
   input  logic [2:0][COORD_BITS-1:0] a_min,
   input  logic [2:0][COORD_BITS-1:0] a_max,
   input  logic [2:0][COORD_BITS-1:0] b_min,
   input  logic [2:0][COORD_BITS-1:0] b_max,
   output logic out_valid,
   input  logic out_stall,
   output logic [2*COORD_BITS+1:0] out_sum,
   output logic [appd_pkg::FLAG_BITS+9*COORD_BITS+2:0] out_side
);
   import appd_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int EW = ((CB > PAD_BITS + 1) ? CB : PAD_BITS + 1) + 2;
   localparam int SW = FLAG_BITS + 9*CB + 3;
   localparam int NS = 3;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   hold;

   flag_type                flag_in;
   logic [2:0][CB-1:0]      pa_in, pb_in, vmag_in;
   logic [2:0]              vneg_in;
   logic [SW-1:0]           side1_in;
   logic [SW-1:0]           side_ff [NS];
   logic [2:0][CB-1:0]      vmag_ff;
   logic [2:0][2*CB-1:0]    sq_in, sq_ff;
   logic [2*CB+1:0]         sum_in, sum_ff;

   always_comb begin
      hold[NS] = out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = vld_ff[i] && hold[i+1];
      end
   end

   always_comb begin
      logic signed [EW-1:0] amin_e, amax_e, bmin_e, bmax_e, pad_e;
      logic signed [CB-1:0] amin, amax, bmin, bmax, omin, omax;
      logic signed [CB:0]   msum;
      logic                 left, right;
      flag_in.ok = 1'b1;
      flag_in.ov = 1'b1;
      pad_e = EW'($signed({1'b0, pad}));
      for (int i = 0; i < 3; i++) begin
         amin = $signed(a_min[i]);
         amax = $signed(a_max[i]);
         bmin = $signed(b_min[i]);
         bmax = $signed(b_max[i]);
         amin_e = EW'(amin);
         amax_e = EW'(amax);
         bmin_e = EW'(bmin);
         bmax_e = EW'(bmax);
         if (amin > amax || bmin > bmax) begin
            flag_in.ok = 1'b0;
         end
         if (!(amin_e <= bmax_e + pad_e && amax_e + pad_e >= bmin_e)) begin
            flag_in.ov = 1'b0;
         end
         omin = (amin > bmin) ? amin : bmin;
         omax = (amax < bmax) ? amax : bmax;
         msum = (CB+1)'(omin) + (CB+1)'(omax);
         left  = amax < bmin;
         right = bmax < amin;
         vneg_in[i] = 1'b0;
         vmag_in[i] = '0;
         if (left) begin
            pa_in[i] = a_max[i];
            pb_in[i] = b_min[i];
            vmag_in[i] = CB'((CB+1)'(bmin) - (CB+1)'(amax));
         end else if (right) begin
            pa_in[i] = a_min[i];
            pb_in[i] = b_max[i];
            vmag_in[i] = CB'((CB+1)'(amin) - (CB+1)'(bmax));
            vneg_in[i] = 1'b1;
         end else if (omin <= omax) begin
            pa_in[i] = msum[CB:1];
            pb_in[i] = msum[CB:1];
         end else begin
            pa_in[i] = a_min[i];
            pb_in[i] = a_min[i];
         end
      end
      side1_in = {flag_in, pa_in, pb_in, vmag_in, vneg_in};
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (2*CB)'(vmag_ff[i]) * (2*CB)'(vmag_ff[i]);
      end
      sum_in = (2*CB+2)'(sq_ff[0]) + (2*CB+2)'(sq_ff[1]) + (2*CB+2)'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (!hold[0]) vld_ff[0] <= in_valid;
         if (!hold[1]) vld_ff[1] <= vld_ff[0];
         if (!hold[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold[0]) begin
         side_ff[0] <= side1_in;
         vmag_ff    <= vmag_in;
      end
      if (!hold[1]) begin
         side_ff[1] <= side_ff[0];
         sq_ff      <= sq_in;
      end
      if (!hold[2]) begin
         side_ff[2] <= side_ff[1];
         sum_ff     <= sum_in;
      end
   end

   assign in_stall  = hold[0];
   assign out_valid = vld_ff[NS-1];
   assign out_sum   = sum_ff;
   assign out_side  = side_ff[NS-1];

endmodule

// ----- sv/appd_sqrt.sv -----
// ---------------------------------------------------------------------------
// appd_sqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module appd_sqrt #(
   parameter int COORD_BITS = appd_pkg::COORD_BITS_DEF,
   parameter int SIDE_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  logic [2*COORD_BITS+1:0] in_rad,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic out_valid,
   input  logic out_stall,
   output logic [COORD_BITS:0] out_root,
   output logic [SIDE_BITS-1:0] out_side
);
   import appd_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int W  = 2*CB + 2;
   localparam int NS = CB + 1;
   localparam int RW = CB + 4;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   hold;

   logic [RW-1:0]        rem_ff  [NS];
   logic [CB:0]          root_ff [NS];
   logic [W-1:0]         rad_ff  [NS];
   logic [SIDE_BITS-1:0] side_ff [NS];

   always_comb begin
      hold[NS] = out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = vld_ff[i] && hold[i+1];
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [RW-1:0]        rem_prev, rem2, trial, rem_in;
      logic [CB:0]          root_prev, root_in;
      logic [W-1:0]         rad_prev;
      logic [SIDE_BITS-1:0] side_prev;
      logic                 vld_prev;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      always_comb begin
         rem2  = {rem_prev[RW-3:0], rad_prev[W-1:W-2]};
         trial = RW'({root_prev, 2'b01});
         if (rem2 >= trial) begin
            rem_in  = rem2 - trial;
            root_in = {root_prev[CB-1:0], 1'b1};
         end else begin
            rem_in  = rem2;
            root_in = {root_prev[CB-1:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (!hold[s]) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (!hold[s]) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= {rad_prev[W-3:0], 2'b00};
            side_ff[s] <= side_prev;
         end
      end
   end

   assign in_stall  = hold[0];
   assign out_valid = vld_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

// ----- sv/appd_div.sv -----
// ---------------------------------------------------------------------------
// appd_div
// three-lane pipelined restoring divider for the direction components
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module appd_div #(
   parameter int COORD_BITS = appd_pkg::COORD_BITS_DEF,
   parameter int SIDE_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  logic [COORD_BITS:0] in_len,
   input  logic [2:0][COORD_BITS-1:0] in_mag,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic out_valid,
   input  logic out_stall,
   output logic [COORD_BITS:0] out_len,
   output logic [2:0][appd_pkg::QUOT_BITS-1:0] out_quot,
   output logic [SIDE_BITS-1:0] out_side
);
   import appd_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int NS = QUOT_BITS;
   localparam int NW = CB + FRAC_SHIFT + 1;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   hold;

   logic [2:0][NW-1:0]        rem_ff  [NS];
   logic [2:0][QUOT_BITS-1:0] quot_ff [NS];
   logic [CB:0]               len_ff  [NS];
   logic [SIDE_BITS-1:0]      side_ff [NS];

   always_comb begin
      hold[NS] = out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = vld_ff[i] && hold[i+1];
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int BIT = NS - 1 - s;
      logic [2:0][NW-1:0]        rem_prev, rem_in;
      logic [2:0][QUOT_BITS-1:0] quot_prev, quot_in;
      logic [CB:0]               len_prev;
      logic [SIDE_BITS-1:0]      side_prev;
      logic                      vld_prev;
      logic [NW-1:0]             dsh;

      if (s == 0) begin : g_first
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_prev[l] = NW'({in_mag[l], {FRAC_SHIFT{1'b0}}});
         end
         assign quot_prev = '0;
         assign len_prev  = in_len;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign len_prev  = len_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      assign dsh = NW'(len_prev) << BIT;

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            quot_in[l] = quot_prev[l];
            if (rem_prev[l] >= dsh) begin
               rem_in[l]       = rem_prev[l] - dsh;
               quot_in[l][BIT] = 1'b1;
            end else begin
               rem_in[l] = rem_prev[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (!hold[s]) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (!hold[s]) begin
            rem_ff[s]  <= rem_in;
            quot_ff[s] <= quot_in;
            len_ff[s]  <= len_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign in_stall  = hold[0];
   assign out_valid = vld_ff[NS-1];
   assign out_len   = len_ff[NS-1];
   assign out_quot  = quot_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

// ----- sv/aabb_pair_distance_closest_points.sv -----
// an accepted item passes the front stages, the root and divide stages and the output register
// throughput: one item per cycle while rsp_stall does not hold the output; the root takes one stage per result bit
// and the direction divide one stage per quotient bit
// a full pipeline stalls the input only while the output register is held
// synchronous reset clears all valid bits and sets overlap_pad to zero
// ---------------------------------------------------------------------------
// aabb_pair_distance_closest_points
// box pair overlap, gap distance, closest points and unit direction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_pair_distance_closest_points #(
   parameter int COORD_BITS = appd_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [appd_pkg::PAD_BITS-1:0] csr_overlap_pad,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [COORD_BITS-1:0] req_a_min_x,
   input  logic signed [COORD_BITS-1:0] req_a_min_y,
   input  logic signed [COORD_BITS-1:0] req_a_min_z,
   input  logic signed [COORD_BITS-1:0] req_a_max_x,
   input  logic signed [COORD_BITS-1:0] req_a_max_y,
   input  logic signed [COORD_BITS-1:0] req_a_max_z,
   input  logic signed [COORD_BITS-1:0] req_b_min_x,
   input  logic signed [COORD_BITS-1:0] req_b_min_y,
   input  logic signed [COORD_BITS-1:0] req_b_min_z,
   input  logic signed [COORD_BITS-1:0] req_b_max_x,
   input  logic signed [COORD_BITS-1:0] req_b_max_y,
   input  logic signed [COORD_BITS-1:0] req_b_max_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_pair_ok,
   output logic rsp_boxes_overlap,
   output logic [COORD_BITS+1:0] rsp_gap_distance,
   output logic signed [COORD_BITS-1:0] rsp_near_a_x,
   output logic signed [COORD_BITS-1:0] rsp_near_a_y,
   output logic signed [COORD_BITS-1:0] rsp_near_a_z,
   output logic signed [COORD_BITS-1:0] rsp_near_b_x,
   output logic signed [COORD_BITS-1:0] rsp_near_b_y,
   output logic signed [COORD_BITS-1:0] rsp_near_b_z,
   output logic signed [appd_pkg::DIR_BITS-1:0] rsp_dir_x,
   output logic signed [appd_pkg::DIR_BITS-1:0] rsp_dir_y,
   output logic signed [appd_pkg::DIR_BITS-1:0] rsp_dir_z
);
   import appd_pkg::*;
   `include "assert_macros.svh"

   localparam int CB  = COORD_BITS;
   localparam int SW1 = FLAG_BITS + 9*CB + 3;
   localparam int SW2 = FLAG_BITS + 6*CB + 3;

   logic [PAD_BITS-1:0] pad_ff;

   logic                 fr_valid, fr_stall;
   logic [2*CB+1:0]      fr_sum;
   logic [SW1-1:0]       fr_side;

   logic                 sq_valid, sq_stall;
   logic [CB:0]          sq_root;
   logic [SW1-1:0]       sq_side;
   flag_type             sq_flag;
   logic [2:0][CB-1:0]   sq_pa, sq_pb, sq_mag;
   logic [2:0]           sq_neg;

   logic                      dv_valid, dv_stall;
   logic [CB:0]               dv_len;
   logic [2:0][QUOT_BITS-1:0] dv_quot;
   logic [SW2-1:0]            dv_side;
   flag_type                  dv_flag;
   logic [2:0][CB-1:0]        dv_pa, dv_pb;
   logic [2:0]                dv_neg;

   logic                     load;
   logic                     rsp_valid_ff;
   flag_type                 flag_ff;
   logic [CB+1:0]            gap_in, gap_ff;
   logic [2:0][CB-1:0]       pa_ff, pb_ff;
   logic [2:0][DIR_BITS-1:0] dir_in, dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= '0;
      end else if (csr_valid) begin
         pad_ff <= csr_overlap_pad;
      end
   end
   assign csr_ready = 1'b1;

   appd_front #(.COORD_BITS(CB)) u_front (
      .clock    (clock),
      .reset    (reset),
      .pad      (pad_ff),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .a_min    ({req_a_min_z, req_a_min_y, req_a_min_x}),
      .a_max    ({req_a_max_z, req_a_max_y, req_a_max_x}),
      .b_min    ({req_b_min_z, req_b_min_y, req_b_min_x}),
      .b_max    ({req_b_max_z, req_b_max_y, req_b_max_x}),
      .out_valid(fr_valid),
      .out_stall(fr_stall),
      .out_sum  (fr_sum),
      .out_side (fr_side)
   );

   appd_sqrt #(.COORD_BITS(CB), .SIDE_BITS(SW1)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_valid),
      .in_stall (fr_stall),
      .in_rad   (fr_sum),
      .in_side  (fr_side),
      .out_valid(sq_valid),
      .out_stall(sq_stall),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   assign {sq_flag, sq_pa, sq_pb, sq_mag, sq_neg} = sq_side;

   appd_div #(.COORD_BITS(CB), .SIDE_BITS(SW2)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sq_valid),
      .in_stall (sq_stall),
      .in_len   (sq_root),
      .in_mag   (sq_mag),
      .in_side  ({sq_flag, sq_pa, sq_pb, sq_neg}),
      .out_valid(dv_valid),
      .out_stall(dv_stall),
      .out_len  (dv_len),
      .out_quot (dv_quot),
      .out_side (dv_side)
   );

   assign {dv_flag, dv_pa, dv_pb, dv_neg} = dv_side;

   always_comb begin
      gap_in = dv_flag.ok ? (CB+2)'(dv_len) : '1;
      for (int i = 0; i < 3; i++) begin
         if (dv_len == '0) begin
            dir_in[i] = '0;
         end else if (!dv_neg[i]) begin
            dir_in[i] = (dv_quot[i] > DIR_POS_MAX) ? DIR_POS_MAX : dv_quot[i];
         end else begin
            dir_in[i] = DIR_BITS'(-dv_quot[i]);
         end
      end
   end

   assign load     = !rsp_valid_ff || !rsp_stall;
   assign dv_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flag_ff.ok <= dv_flag.ok;
         flag_ff.ov <= dv_flag.ok && dv_flag.ov;
         gap_ff     <= gap_in;
         pa_ff      <= dv_pa;
         pb_ff      <= dv_pb;
         dir_ff     <= dir_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pair_ok       = flag_ff.ok;
   assign rsp_boxes_overlap = flag_ff.ov;
   assign rsp_gap_distance  = gap_ff;
   assign rsp_near_a_x      = pa_ff[0];
   assign rsp_near_a_y      = pa_ff[1];
   assign rsp_near_a_z      = pa_ff[2];
   assign rsp_near_b_x      = pb_ff[0];
   assign rsp_near_b_y      = pb_ff[1];
   assign rsp_near_b_z      = pb_ff[2];
   assign rsp_dir_x         = dir_ff[0];
   assign rsp_dir_y         = dir_ff[1];
   assign rsp_dir_z         = dir_ff[2];

   `APD_ASSERT_IMP(a_ovl_ok, rsp_valid && rsp_boxes_overlap, rsp_pair_ok, "overlap without ok pair")
   `APD_ASSERT_IMP(a_bad_sat, rsp_valid && !rsp_pair_ok, &rsp_gap_distance, "bad pair not saturated")
   `APD_ASSERT_IMP(a_zero_dir, rsp_valid && rsp_pair_ok && rsp_gap_distance == '0, rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0, "nonzero dir at zero gap")
   `APD_ASSERT_IMP(a_stall_src, req_stall, rsp_valid && rsp_stall, "input stalled with output free")

endmodule
